/* src/lbc_pkg.sv */
// shared types, constants and codes of the band cache policy
`default_nettype none

package lbc_pkg;

    localparam int BAND_W         = 16;
    localparam int STAMP_W        = 16;
    localparam int SLOT_W         = 4;
    localparam int CNT_W          = 4;
    localparam int STATUS_W       = 2;
    localparam int MAX_SLOTS_DEF  = 12;
    localparam int TAG_BITS_DEF   = 16;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 4'd12;

    // register index, taken from paddr[2]
    localparam logic REG_SLOT_COUNT = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FILL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RESET  = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [BAND_W-1:0] band_index;
        logic              band_present;
    } lbc_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } lbc_out_t;

    typedef struct packed {
        logic clear;
        logic tag_we;
        logic stamp_we;
    } lbc_wr_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } lbc_state_t;

endpackage

`default_nettype wire

/* src/lru_band_cache_policy.sv */
// top level of the band cache policy: config register and unit wiring
//
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  lbc_in_t  (mode, band_index, band_present)
// m_        out        m_valid / m_ready  lbc_out_t (status, slot)
// apb       in         psel/penable       slot_count at byte address 0
//
// a lookup runs from idle through the scan, which ends on a hit or at the last
// active slot, to the update state that registers the result; a slot reset skips the scan
// the scan visits one slot a cycle through the shared tag and stamp compare unit
// one transaction is in work at a time; s_ready is high only while idle
// a result held by m_ready low stalls the directory update until it is taken
// reset clears every slot to empty, the stamps and clock to zero, slot_count to 12
`default_nettype none

module lru_band_cache_policy #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lbc_pkg::TAG_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire lbc_pkg::lbc_in_t               s_data,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output lbc_pkg::lbc_out_t                   m_data,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [lbc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire [lbc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lbc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam logic [lbc_pkg::CNT_W:0] MAX_N = (lbc_pkg::CNT_W + 1)'(MAX_SLOTS);

    logic [lbc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]            last_idx;
    logic [lbc_pkg::CNT_W:0]     count_ext;
    logic                        cfg_sel;

    logic                        step;
    logic [IDX_W-1:0]            idx;
    logic [TAG_BITS-1:0]         key_tag;
    logic                        key_ok;
    logic                        hit_now;
    logic                        hit;
    logic [IDX_W-1:0]            hit_idx;
    logic [IDX_W-1:0]            victim;
    lbc_pkg::lbc_wr_ctl_t        wr_ctl;
    logic [IDX_W-1:0]            wr_idx;
    logic [TAG_BITS-1:0]         wr_tag;
    logic [lbc_pkg::STAMP_W-1:0] wr_stamp;
    logic [TAG_BITS-1:0]         rd_tag;
    logic [lbc_pkg::STAMP_W-1:0] rd_stamp;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == lbc_pkg::REG_SLOT_COUNT);

    always_comb begin
        count_next = count_reg;
        if (psel && penable && pwrite && cfg_sel) begin
            count_next = pwdata[lbc_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= lbc_pkg::SLOT_COUNT_RST;
        end else begin
            count_reg <= count_next;
        end
    end

    assign prdata = cfg_sel ? lbc_pkg::APB_DATA_W'(count_reg) : '0;

    // active slot count clamped to 2..MAX_SLOTS, as a last index
    assign count_ext = {1'b0, count_reg};

    always_comb begin
        priority if (count_ext < (lbc_pkg::CNT_W + 1)'(2)) begin
            last_idx = IDX_W'(1);
        end else if (count_ext > MAX_N) begin
            last_idx = IDX_W'(MAX_N - 1'b1);
        end else begin
            last_idx = IDX_W'(count_ext - 1'b1);
        end
    end

    lbc_seq #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .last_idx (last_idx),
        .hit_now  (hit_now),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .victim   (victim),
        .step     (step),
        .idx      (idx),
        .key_tag  (key_tag),
        .key_ok   (key_ok),
        .wr_ctl   (wr_ctl),
        .wr_idx   (wr_idx),
        .wr_tag   (wr_tag),
        .wr_stamp (wr_stamp)
    );

    lbc_scan #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .idx      (idx),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp),
        .key_tag  (key_tag),
        .key_ok   (key_ok),
        .hit_now  (hit_now),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .victim   (victim)
    );

    lbc_slot_store #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_ctl   (wr_ctl),
        .wr_idx   (wr_idx),
        .wr_tag   (wr_tag),
        .wr_stamp (wr_stamp),
        .rd_idx   (idx),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp)
    );

endmodule

`default_nettype wire

/* src/lbc_slot_store.sv */
// slot tag and stamp storage, one read and one write address
`default_nettype none

module lbc_slot_store #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lbc_pkg::TAG_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire lbc_pkg::lbc_wr_ctl_t           wr_ctl,
    input  wire [$clog2(MAX_SLOTS)-1:0]         wr_idx,
    input  wire [TAG_BITS-1:0]                  wr_tag,
    input  wire [lbc_pkg::STAMP_W-1:0]          wr_stamp,
    input  wire [$clog2(MAX_SLOTS)-1:0]         rd_idx,
    output logic [TAG_BITS-1:0]                 rd_tag,
    output logic [lbc_pkg::STAMP_W-1:0]         rd_stamp
);

    logic [TAG_BITS-1:0]         tag_reg   [MAX_SLOTS];
    logic [lbc_pkg::STAMP_W-1:0] stamp_reg [MAX_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn || wr_ctl.clear) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                tag_reg[i]   <= '1;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (wr_ctl.tag_we) begin
                tag_reg[wr_idx] <= wr_tag;
            end
            if (wr_ctl.stamp_we) begin
                stamp_reg[wr_idx] <= wr_stamp;
            end
        end
    end

    assign rd_tag   = tag_reg[rd_idx];
    assign rd_stamp = stamp_reg[rd_idx];

endmodule

`default_nettype wire

/* src/lbc_scan.sv */
// shared compare unit: tag match and oldest stamp, one slot a cycle while step is high
`default_nettype none

module lbc_scan #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lbc_pkg::TAG_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 step,
    input  wire [$clog2(MAX_SLOTS)-1:0]         idx,
    input  wire [TAG_BITS-1:0]                  rd_tag,
    input  wire [lbc_pkg::STAMP_W-1:0]          rd_stamp,
    input  wire [TAG_BITS-1:0]                  key_tag,
    input  wire                                 key_ok,
    output logic                                hit_now,
    output logic                                hit,
    output logic [$clog2(MAX_SLOTS)-1:0]        hit_idx,
    output logic [$clog2(MAX_SLOTS)-1:0]        victim
);

    localparam int IDX_W = $clog2(MAX_SLOTS);

    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]            victim_reg, victim_next;
    logic [lbc_pkg::STAMP_W-1:0] min_reg, min_next;
    logic                        first;

    assign hit_now = key_ok && (rd_tag == key_tag);
    assign first   = (idx == '0);

    always_comb begin
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        victim_next  = victim_reg;
        min_next     = min_reg;
        if (step) begin
            if (hit_now) begin
                hit_next     = 1'b1;
                hit_idx_next = idx;
            end else if (first) begin
                hit_next = 1'b0;
            end
            if (first || (rd_stamp < min_reg)) begin
                min_next    = rd_stamp;
                victim_next = idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
        hit_idx_reg <= hit_idx_next;
        victim_reg  <= victim_next;
        min_reg     <= min_next;
    end

    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;
    assign victim  = victim_reg;

endmodule

`default_nettype wire

/* src/lbc_seq.sv */
// sequencer: item capture, slot scan, directory update and result register
`default_nettype none

module lbc_seq #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF,
    parameter int TAG_BITS  = lbc_pkg::TAG_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire lbc_pkg::lbc_in_t               s_data,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output lbc_pkg::lbc_out_t                   m_data,
    input  wire [$clog2(MAX_SLOTS)-1:0]         last_idx,
    input  wire                                 hit_now,
    input  wire                                 hit,
    input  wire [$clog2(MAX_SLOTS)-1:0]         hit_idx,
    input  wire [$clog2(MAX_SLOTS)-1:0]         victim,
    output logic                                step,
    output logic [$clog2(MAX_SLOTS)-1:0]        idx,
    output logic [TAG_BITS-1:0]                 key_tag,
    output logic                                key_ok,
    output lbc_pkg::lbc_wr_ctl_t                wr_ctl,
    output logic [$clog2(MAX_SLOTS)-1:0]        wr_idx,
    output logic [TAG_BITS-1:0]                 wr_tag,
    output logic [lbc_pkg::STAMP_W-1:0]         wr_stamp
);

    localparam int IDX_W = $clog2(MAX_SLOTS);

    lbc_pkg::lbc_state_t         state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        mode_reg, mode_next;
    logic                        present_reg, present_next;
    logic [TAG_BITS-1:0]         tag_reg, tag_next;
    logic [lbc_pkg::STAMP_W-1:0] clock_reg, clock_next;
    logic                        m_valid_reg, m_valid_next;
    lbc_pkg::lbc_out_t           m_data_reg, m_data_next;

    logic                        accept;
    logic                        out_free;
    logic                        scan_done;
    logic [lbc_pkg::STAMP_W-1:0] clock_inc;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = hit_now || (idx_reg == last_idx);
    assign clock_inc = clock_reg + 1'b1;
    assign key_ok    = (tag_reg != '1);
    assign key_tag   = tag_reg;
    assign idx       = idx_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbc_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = s_data.mode ? lbc_pkg::S_UPDATE : lbc_pkg::S_SCAN;
                end
            end
            lbc_pkg::S_SCAN: begin
                if (scan_done) begin
                    state_next = lbc_pkg::S_UPDATE;
                end
            end
            lbc_pkg::S_UPDATE: begin
                if (out_free) begin
                    state_next = lbc_pkg::S_IDLE;
                end
            end
            default: state_next = lbc_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready      = 1'b0;
        step         = 1'b0;
        wr_ctl       = '0;
        wr_idx       = victim;
        wr_tag       = tag_reg;
        wr_stamp     = clock_inc;
        idx_next     = idx_reg;
        mode_next    = mode_reg;
        present_next = present_reg;
        tag_next     = tag_reg;
        clock_next   = clock_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            lbc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    idx_next     = '0;
                    mode_next    = s_data.mode;
                    present_next = s_data.band_present;
                    tag_next     = TAG_BITS'(s_data.band_index);
                end
            end
            lbc_pkg::S_SCAN: begin
                step = 1'b1;
                if (!scan_done) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            lbc_pkg::S_UPDATE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (mode_reg) begin
                        wr_ctl.clear       = 1'b1;
                        clock_next         = '0;
                        m_data_next.status = lbc_pkg::STATUS_RESET;
                        m_data_next.slot   = '0;
                    end else if (hit) begin
                        wr_ctl.stamp_we    = 1'b1;
                        wr_idx             = hit_idx;
                        clock_next         = clock_inc;
                        m_data_next.status = lbc_pkg::STATUS_HIT;
                        m_data_next.slot   = lbc_pkg::SLOT_W'(hit_idx);
                    end else if (present_reg && key_ok) begin
                        wr_ctl.tag_we      = 1'b1;
                        wr_ctl.stamp_we    = 1'b1;
                        clock_next         = clock_inc;
                        m_data_next.status = lbc_pkg::STATUS_FILL;
                        m_data_next.slot   = lbc_pkg::SLOT_W'(victim);
                    end else begin
                        wr_ctl.tag_we      = 1'b1;
                        wr_tag             = '1;
                        m_data_next.status = lbc_pkg::STATUS_ABSENT;
                        m_data_next.slot   = lbc_pkg::SLOT_W'(victim);
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbc_pkg::S_IDLE;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        mode_reg    <= mode_next;
        present_reg <= present_next;
        tag_reg     <= tag_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
